### sv/cmt_pkg.sv
// cmt_pkg: shared types and codes for the contact manifold table.
// No dependencies.
package cmt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;
    localparam logic [1:0] OP_PRUNE  = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_SHALLOW  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [31:0] DUP_RESET = 32'd655;
    localparam logic [31:0] SEP_RESET = 32'hFFFF_E666;

    localparam logic [0:0] REG_DUP = 1'b0;
    localparam logic [0:0] REG_SEP = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] d;
    } point_t;

endpackage

### sv/cmt_near.sv
// cmt_near: multi-cycle proximity test, one squared axis per cycle.
// Depends on cmt_pkg.
module cmt_near
    import cmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  point_t      a,
    input  point_t      b,
    input  logic [30:0] thr,
    output logic        done,
    output logic        near
);
    logic [1:0]  axis_reg, axis_next;
    logic        busy_reg, busy_next;
    logic [63:0] acc_reg, acc_next;
    logic        far_reg, far_next;
    logic        done_reg, done_next;
    logic signed [32:0] diff;
    logic [32:0] mag;
    logic [63:0] sq;
    logic [61:0] tt;

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    diff = 33'(a.x) - 33'(b.x);
            2'd1:    diff = 33'(a.y) - 33'(b.y);
            default: diff = 33'(a.z) - 33'(b.z);
        endcase
        mag = diff[32] ? 33'(-diff) : 33'(diff);
        sq  = mag[31:0] * mag[31:0];
        tt  = 62'(thr) * 62'(thr);
        busy_next = busy_reg;
        axis_next = axis_reg;
        acc_next  = acc_reg;
        far_next  = far_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            axis_next = 2'd0;
            acc_next  = '0;
            far_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (mag >= 33'(thr))
                far_next = 1'b1;
            else
                acc_next = acc_reg + sq;
            if (axis_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                axis_next = axis_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            axis_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            axis_reg <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        far_reg <= far_next;
    end

    assign done = done_reg;
    assign near = !far_reg && (thr != 31'd0) && (acc_reg < 64'(tt));
endmodule

### sv/cmt_div.sv
// cmt_div: restoring signed divider of a 36-bit sum by a small count.
// Depends on nothing.
module cmt_div #(
    parameter int CW = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [35:0] num,
    input  logic [CW-1:0]      den,
    output logic               done,
    output logic [31:0]        quo
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [35:0] q_reg, q_next;
    logic [CW:0] r_reg, r_next;
    logic        neg_reg, neg_next;
    logic [CW:0] trial;
    logic [35:0] qs;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {r_reg[CW-1:0], q_reg[35]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            neg_next  = num[35];
            q_next    = num[35] ? 36'(-num) : 36'(num);
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[34:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[34:0], 1'b0};
            end
            if (cnt_reg == 6'd35)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

    assign qs   = neg_reg ? 36'(-q_reg) : q_reg;
    assign quo  = qs[31:0];
    assign done = done_reg;
endmodule

### sv/contact_manifold_table_core.sv
// Contact manifold table: point list with add, remove, merge and prune.
// Each add runs a proximity test per stored point and each merge one per pair;
// each transfer then computes four means, each a sum divided by the count.
// Throughput: one transfer at a time; not ready while busy or a result waits.
// Reset: count cleared, registers to defaults; point storage undefined.
// Depends on cmt_pkg, cmt_near, cmt_div.
module contact_manifold_table_core
    import cmt_pkg::*;
#(
    parameter int MAX_POINTS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] depth,
    input  logic [30:0]        merge_tolerance,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [2:0]         entry_count,
    output logic signed [31:0] mean_depth,
    output logic signed [31:0] center_x,
    output logic signed [31:0] center_y,
    output logic signed [31:0] center_z
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DUP    = 4'd1;
    localparam logic [3:0] S_DUPW   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_APPLY  = 4'd4;
    localparam logic [3:0] S_MRG    = 4'd5;
    localparam logic [3:0] S_MRGW   = 4'd6;
    localparam logic [3:0] S_ERASE  = 4'd7;
    localparam logic [3:0] S_PRUNE  = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_DIVW   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    point_t pts_reg [MAX_POINTS];
    point_t pts_next [MAX_POINTS];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    st_reg, st_next;
    logic [1:0]    op_reg, op_next;
    point_t        np_reg, np_next;
    logic [30:0]   tol_reg, tol_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, ek_reg, ek_next;
    logic [IW-1:0] m_reg, m_next;
    logic          dup_reg, dup_next;
    logic [3:0]    ret_reg, ret_next;
    logic [2:0]    stat_reg, stat_next;
    logic [1:0]    f_reg, f_next;
    logic signed [35:0] sum_reg, sum_next;
    logic [31:0]   res_reg [4];
    logic [31:0]   res_next [4];
    logic          ov_reg, ov_next;
    logic [30:0]   dup_dist_reg;
    logic [31:0]   sep_reg;

    logic   nstart, ndone, nnear, dstart, ddone;
    point_t na, nb;
    logic [30:0] nthr;
    logic [31:0] dquo;

    cmt_near u_near (
        .clk(clk), .rst_n(rst_n), .start(nstart), .a(na), .b(nb),
        .thr(nthr), .done(ndone), .near(nnear)
    );

    cmt_div #(.CW(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(sum_reg),
        .den(cnt_reg), .done(ddone), .quo(dquo)
    );

    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[2])
            REG_DUP: prdata = {1'b0, dup_dist_reg};
            default: prdata = sep_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_dist_reg <= DUP_RESET[30:0];
            sep_reg      <= SEP_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_DUP)
                dup_dist_reg <= pwdata[30:0];
            else
                sep_reg <= pwdata;
        end
    end

    function automatic logic signed [31:0] fsel(point_t p, logic [1:0] f);
        logic signed [31:0] v;
        unique case (f)
            2'd0:    v = p.d;
            2'd1:    v = p.x;
            2'd2:    v = p.y;
            default: v = p.z;
        endcase
        return v;
    endfunction

    always_comb
    begin
        pts_next  = pts_reg;
        cnt_next  = cnt_reg;
        st_next   = st_reg;
        op_next   = op_reg;
        np_next   = np_reg;
        tol_next  = tol_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        ek_next   = ek_reg;
        m_next    = m_reg;
        dup_next  = dup_reg;
        ret_next  = ret_reg;
        stat_next = stat_reg;
        f_next    = f_reg;
        sum_next  = sum_reg;
        res_next  = res_reg;
        ov_next   = ov_reg;
        nstart    = 1'b0;
        dstart    = 1'b0;
        na        = np_reg;
        nb        = pts_reg[i_reg[IW-1:0]];
        nthr      = dup_dist_reg;
        if (st_reg == S_MRG || st_reg == S_MRGW)
        begin
            na   = pts_reg[i_reg[IW-1:0]];
            nb   = pts_reg[j_reg[IW-1:0]];
            nthr = tol_reg;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op;
                    np_next   = '{x: point_x, y: point_y, z: point_z, d: depth};
                    tol_next  = merge_tolerance;
                    i_next    = '0;
                    j_next    = CW'(1);
                    m_next    = '0;
                    dup_next  = 1'b0;
                    stat_next = ST_DONE;
                    unique case (op)
                        OP_ADD:    st_next = S_DUP;
                        OP_REMOVE: st_next = S_SCAN;
                        OP_MERGE:  st_next = S_MRG;
                        default:   st_next = S_PRUNE;
                    endcase
                end
            end
            S_DUP:
            begin
                if (i_reg < cnt_reg)
                begin
                    nstart  = 1'b1;
                    st_next = S_DUPW;
                end
                else
                begin
                    i_next  = CW'(1);
                    st_next = dup_next ? S_APPLY : S_SCAN;
                    if (!dup_reg && cnt_reg < CW'(MAX_POINTS))
                        st_next = S_APPLY;
                    else if (!dup_reg)
                        st_next = S_SCAN;
                end
            end
            S_DUPW:
            begin
                if (ndone)
                begin
                    if (nnear)
                        dup_next = 1'b1;
                    i_next  = i_reg + CW'(1);
                    st_next = S_DUP;
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_REMOVE && cnt_reg == '0)
                begin
                    stat_next = ST_EMPTY;
                    st_next   = S_SUM;
                    f_next    = '0;
                    sum_next  = '0;
                    i_next    = '0;
                end
                else if (i_reg < cnt_reg && i_reg != '0)
                begin
                    if (op_reg == OP_ADD
                        ? pts_reg[i_reg[IW-1:0]].d < pts_reg[m_reg].d
                        : pts_reg[i_reg[IW-1:0]].d > pts_reg[m_reg].d)
                        m_next = i_reg[IW-1:0];
                    i_next = i_reg + CW'(1);
                end
                else if (i_reg == '0)
                    i_next = CW'(1);
                else
                    st_next = S_APPLY;
            end
            S_APPLY:
            begin
                st_next  = S_SUM;
                f_next   = '0;
                sum_next = '0;
                i_next   = '0;
                if (op_reg == OP_REMOVE)
                begin
                    ek_next = CW'(m_reg);
                    ret_next = S_SUM;
                    st_next = S_ERASE;
                end
                else if (dup_reg)
                    stat_next = ST_DUP;
                else if (cnt_reg < CW'(MAX_POINTS))
                begin
                    pts_next[cnt_reg[IW-1:0]] = np_reg;
                    cnt_next = cnt_reg + CW'(1);
                end
                else if (np_reg.d > pts_reg[m_reg].d)
                begin
                    pts_next[m_reg] = np_reg;
                    stat_next = ST_REPLACED;
                end
                else
                    stat_next = ST_SHALLOW;
            end
            S_MRG:
            begin
                if (i_reg >= cnt_reg)
                begin
                    st_next  = S_SUM;
                    f_next   = '0;
                    sum_next = '0;
                    i_next   = '0;
                end
                else if (j_reg >= cnt_reg)
                begin
                    i_next = i_reg + CW'(1);
                    j_next = i_reg + CW'(2);
                end
                else
                begin
                    nstart  = 1'b1;
                    st_next = S_MRGW;
                end
            end
            S_MRGW:
            begin
                if (ndone)
                begin
                    if (nnear)
                    begin
                        if (pts_reg[i_reg[IW-1:0]].d < pts_reg[j_reg[IW-1:0]].d)
                            pts_next[i_reg[IW-1:0]] = pts_reg[j_reg[IW-1:0]];
                        ek_next  = j_reg;
                        ret_next = S_MRG;
                        st_next  = S_ERASE;
                    end
                    else
                    begin
                        j_next  = j_reg + CW'(1);
                        st_next = S_MRG;
                    end
                end
            end
            S_ERASE:
            begin
                if (ek_reg + CW'(1) < cnt_reg)
                begin
                    pts_next[ek_reg[IW-1:0]] = pts_reg[IW'(ek_reg + CW'(1))];
                    ek_next = ek_reg + CW'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                    st_next  = ret_reg;
                    if (ret_reg == S_SUM)
                    begin
                        f_next   = '0;
                        sum_next = '0;
                        i_next   = '0;
                    end
                end
            end
            S_PRUNE:
            begin
                if (i_reg >= cnt_reg)
                begin
                    st_next  = S_SUM;
                    f_next   = '0;
                    sum_next = '0;
                    i_next   = '0;
                end
                else if ($signed(pts_reg[i_reg[IW-1:0]].d) < $signed(sep_reg))
                begin
                    ek_next  = i_reg;
                    ret_next = S_PRUNE;
                    st_next  = S_ERASE;
                end
                else
                    i_next = i_reg + CW'(1);
            end
            S_SUM:
            begin
                if (i_reg < cnt_reg)
                begin
                    sum_next = sum_reg + 36'(fsel(pts_reg[i_reg[IW-1:0]], f_reg));
                    i_next   = i_reg + CW'(1);
                end
                else if (cnt_reg == '0)
                begin
                    res_next[f_reg] = '0;
                    st_next = S_DIVW;
                end
                else
                    st_next = S_DIV;
            end
            S_DIV:
            begin
                dstart  = 1'b1;
                st_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (ddone || cnt_reg == '0)
                begin
                    if (cnt_reg != '0)
                        res_next[f_reg] = dquo;
                    if (f_reg == 2'd3)
                    begin
                        ov_next = 1'b1;
                        st_next = S_OUT;
                    end
                    else
                    begin
                        f_next   = f_reg + 2'd1;
                        sum_next = '0;
                        i_next   = '0;
                        st_next  = S_SUM;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg  <= pts_next;
        op_reg   <= op_next;
        np_reg   <= np_next;
        tol_reg  <= tol_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        ek_reg   <= ek_next;
        m_reg    <= m_next;
        dup_reg  <= dup_next;
        ret_reg  <= ret_next;
        stat_reg <= stat_next;
        f_reg    <= f_next;
        sum_reg  <= sum_next;
        res_reg  <= res_next;
    end

    assign in_stall    = (st_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = stat_reg;
    assign entry_count = 3'(cnt_reg);
    assign mean_depth  = res_reg[0];
    assign center_x    = res_reg[1];
    assign center_y    = res_reg[2];
    assign center_z    = res_reg[3];

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count overflow");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result pending while accepting");
    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && entry_count == 3'd0) |-> (mean_depth == 32'd0))
        else $error("non-zero mean on empty list");
`endif
endmodule

### verif/cmt_checker.sv
// cmt_checker: watches both channels of the contact manifold table, predicts each
// result from its own copy of the point list and registers, and counts mismatches.
// Depends on cmt_pkg.
module cmt_checker
    import cmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [31:0] depth,
    input  logic [30:0]        merge_tolerance,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         status,
    input  logic [2:0]         entry_count,
    input  logic signed [31:0] mean_depth,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [2:0]         st;
        logic [2:0]         cnt;
        logic signed [31:0] md;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } summary_t;

    point_t     pts[4];
    int         npts;
    logic [30:0] dup_dist;
    logic signed [31:0] sep_lim;
    summary_t   summaries_due[$];

    function automatic bit is_close(point_t a, point_t b, logic [30:0] r);
        longint dx, dy, dz, t;
        longint unsigned s;
        dx = longint'(a.x) - longint'(b.x);
        dy = longint'(a.y) - longint'(b.y);
        dz = longint'(a.z) - longint'(b.z);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        t = longint'(r);
        if (dx >= t || dy >= t || dz >= t)
            return 0;
        s = longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy));
        s = s + longint'(unsigned'(dz * dz));
        return s < longint'(unsigned'(t * t));
    endfunction

    task automatic drop_point(int k);
        for (int i = k; i + 1 < npts; i++)
            pts[i] = pts[i + 1];
        npts--;
    endtask

    function automatic logic signed [31:0] avg(int sel);
        longint s;
        s = 0;
        if (npts == 0)
            return 0;
        for (int i = 0; i < npts; i++)
            case (sel)
                0: s += pts[i].d;
                1: s += pts[i].x;
                2: s += pts[i].y;
                default: s += pts[i].z;
            endcase
        return 32'(s / npts);
    endfunction

    task automatic apply_op();
        summary_t r;
        point_t p;
        int m, j;
        bit dup;
        r.st = ST_DONE;
        p = '{point_x, point_y, point_z, depth};
        case (op)
            OP_ADD:
            begin
                dup = 0;
                for (int i = 0; i < npts; i++)
                    if (is_close(p, pts[i], dup_dist))
                        dup = 1;
                if (dup)
                    r.st = ST_DUP;
                else if (npts < 4)
                begin
                    pts[npts] = p;
                    npts++;
                end
                else
                begin
                    m = 0;
                    for (int i = 1; i < npts; i++)
                        if (pts[i].d < pts[m].d)
                            m = i;
                    if (p.d > pts[m].d)
                    begin
                        pts[m] = p;
                        r.st = ST_REPLACED;
                    end
                    else
                        r.st = ST_SHALLOW;
                end
            end
            OP_REMOVE:
            begin
                if (npts == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    m = 0;
                    for (int i = 1; i < npts; i++)
                        if (pts[i].d > pts[m].d)
                            m = i;
                    drop_point(m);
                end
            end
            OP_MERGE:
            begin
                for (int i = 0; i < npts; i++)
                begin
                    j = i + 1;
                    while (j < npts)
                        if (is_close(pts[i], pts[j], merge_tolerance))
                        begin
                            if (pts[i].d < pts[j].d)
                                pts[i] = pts[j];
                            drop_point(j);
                        end
                        else
                            j++;
                end
            end
            default:
            begin
                j = 0;
                while (j < npts)
                    if (pts[j].d < sep_lim)
                        drop_point(j);
                    else
                        j++;
            end
        endcase
        r.cnt = 3'(npts);
        r.md = avg(0);
        r.cx = avg(1);
        r.cy = avg(2);
        r.cz = avg(3);
        summaries_due = {summaries_due, r};
    endtask

    task automatic check_field(string name, longint e, longint a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        summary_t e;
        if (!rst_n)
        begin
            npts = 0;
            dup_dist = 31'(DUP_RESET);
            sep_lim = SEP_RESET;
            fail_count = 0;
            summaries_due.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_DUP)
                    dup_dist = pwdata[30:0];
                else
                    sep_lim = pwdata;
            end
            if (out_valid && !out_stall)
            begin
                if (summaries_due.size() == 0)
                begin
                    $error("result with none expected");
                    fail_count++;
                end
                else
                begin
                    e = summaries_due.pop_front();
                    check_field("status", e.st, status);
                    check_field("entry_count", e.cnt, entry_count);
                    check_field("mean_depth", e.md, mean_depth);
                    check_field("center_x", e.cx, center_x);
                    check_field("center_y", e.cy, center_y);
                    check_field("center_z", e.cz, center_z);
                end
            end
            if (in_valid && !in_stall)
                apply_op();
            pending = summaries_due.size();
        end
    end

endmodule

### verif/tb.sv
// tb: stimulus and verdict for contact_manifold_table_core; results are checked
// by cmt_checker. Depends on cmt_pkg, contact_manifold_table_core, cmt_checker.
module tb;
    import cmt_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         op = OP_ADD;
    logic signed [31:0] point_x = 0, point_y = 0, point_z = 0, depth = 0;
    logic [30:0]        merge_tolerance = '0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [2:0]         status, entry_count;
    logic signed [31:0] mean_depth, center_x, center_y, center_z;
    int                 fail_count, pending;
    int                 send_idle = 0, recv_idle = 0;
    bit                 hold_off = 0;
    longint             cycles = 0;

    always #6 clk = ~clk;

    contact_manifold_table_core u_top (.*);

    cmt_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        if (hold_off)
            out_stall <= 1;
        else
            out_stall <= ($urandom_range(99) < recv_idle);

    task automatic write_reg(logic [0:0] idx, logic [31:0] v);
        psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic send(logic [1:0] o, logic signed [31:0] x, y, z, d,
                        logic [30:0] tol);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; op <= o;
        point_x <= x; point_y <= y; point_z <= z; depth <= d;
        merge_tolerance <= tol;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // points near a small cluster when near_mode is set, so duplicates and merges happen
    task automatic send_random(int near_mode);
        logic signed [31:0] x, y, z, d;
        int r;
        r = $urandom_range(99);
        if (near_mode != 0)
        begin
            x = $signed($urandom_range(4000)) - 2000;
            y = $signed($urandom_range(4000)) - 2000;
            z = $signed($urandom_range(4000)) - 2000;
            d = $signed($urandom_range(40000)) - 20000;
        end
        else
        begin
            x = $urandom; y = $urandom; z = $urandom; d = $urandom;
        end
        if (r < 55)
            send(OP_ADD, x, y, z, d, 31'($urandom));
        else if (r < 75)
            send(OP_REMOVE, $urandom, $urandom, $urandom, $urandom, 31'($urandom));
        else if (r < 88)
            send(OP_MERGE, $urandom, $urandom, $urandom, $urandom,
                 (near_mode != 0) ? 31'($urandom_range(3000)) : 31'($urandom));
        else
            send(OP_PRUNE, x, y, z, d, 31'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(OP_REMOVE, 0, 0, 0, 0, '0);
        send(OP_MERGE, 0, 0, 0, 0, 31'h7FFF_FFFF);
        send(OP_PRUNE, 0, 0, 0, 0, '0);
        send(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
        send(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
        send(OP_ADD, 100, 0, 0, 5, '0);
        send(OP_ADD, 500, 0, 0, 6, '0);
        send(OP_ADD, 100, 600, 0, 7, '0);
        send(OP_ADD, 0, 0, 0, 32'h8000_0000, '0);
        send(OP_ADD, 9000, 0, 0, 32'h8000_0000, '0);
        send(OP_ADD, 9000, 0, 0, 1, '0);
        send(OP_MERGE, 0, 0, 0, 0, '0);
        send(OP_MERGE, 0, 0, 0, 0, 31'h7FFF_FFFF);
        send(OP_PRUNE, 0, 0, 0, 0, '0);
        send(OP_REMOVE, 0, 0, 0, 0, '0);
        send(OP_REMOVE, 0, 0, 0, 0, '0);
        send(OP_ADD, -1, -1, -1, -7000, '0);
        send(OP_PRUNE, 0, 0, 0, 0, '0);
        drain();

        write_reg(REG_DUP, 32'd0);
        write_reg(REG_SEP, 32'h8000_0000);
        for (int i = 0; i < 6; i++) send(OP_ADD, 0, 0, 0, i, '0);
        send(OP_PRUNE, 0, 0, 0, 0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_DUP, 32'h7FFF_FFFF); write_reg(REG_SEP, 32'h7FFF_FFFF); end
                1: begin write_reg(REG_DUP, 32'd1500); write_reg(REG_SEP, 32'hFFFF_FFFF); end
                2: begin write_reg(REG_DUP, $urandom); write_reg(REG_SEP, $urandom); end
                default: begin write_reg(REG_DUP, 32'd655); write_reg(REG_SEP, 32'hFFFF_E666); end
            endcase
            send_idle = (ph < 2) ? ((ph == 0) ? 31 : 65) : 0;
            recv_idle = (ph < 2) ? ((ph == 0) ? 65 : 31) : 0;
            for (int i = 0; i < 200; i++)
                send_random(($urandom_range(99) < 75) ? 1 : 0);
            if (ph == 1)
            begin
                hold_off = 1;
                fork
                    begin
                        repeat (600) @(posedge clk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 6; i++) send_random(1);
                join
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
